// File: design/tlpc_pkg.sv
// Package for the touch long-press classifier: command and action codes,
// register map, reset values and the configuration struct.
// No dependencies; every other design file imports it.
package tlpc_pkg;

   localparam int unsigned TIME_W   = 24;
   localparam int unsigned DEB_W    = 8;
   localparam int unsigned CMD_W    = 2;
   localparam int unsigned ACT_W    = 3;
   localparam int unsigned CSR_AW   = 4;
   localparam int unsigned CSR_DW   = 32;
   localparam int unsigned REG_IDX_W = 2;

   // Command codes carried by an input beat.
   localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_STOP   = 2'd2;

   // Action codes reported in a result beat.
   localparam logic [ACT_W-1:0] ACT_NONE     = 3'd0;
   localparam logic [ACT_W-1:0] ACT_CONFIRM  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_UNLOCK   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_SHUTDOWN = 3'd3;
   localparam logic [ACT_W-1:0] ACT_VALIDATE = 3'd4;
   localparam logic [ACT_W-1:0] ACT_LOCK     = 3'd5;

   // Register indexes; register i sits at byte address 4*i.
   localparam logic [REG_IDX_W-1:0] REG_RELEASE_DEBOUNCE = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_SHORT_HOLD       = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_LONG_HOLD        = 2'd2;

   localparam logic [DEB_W-1:0]  RELEASE_DEBOUNCE_RST = 8'd3;
   localparam logic [TIME_W-1:0] SHORT_HOLD_RST       = 24'd78643;
   localparam logic [TIME_W-1:0] LONG_HOLD_RST        = 24'd327680;

   localparam logic [DEB_W-1:0]  RELEASE_COUNT_MAX = '1;

   typedef struct packed {
      logic [DEB_W-1:0]  release_debounce;
      logic [TIME_W-1:0] short_hold_ticks;
      logic [TIME_W-1:0] long_hold_ticks;
   } cfg_type;

endpackage

// File: design/tlpc_csr.sv
// APB-style register file for the touch long-press classifier thresholds.
// Depends on tlpc_pkg for the register map, reset values and cfg_type.
module tlpc_csr
   import tlpc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic wr_en;

   assign reg_idx    = csr_paddr[CSR_AW-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_RELEASE_DEBOUNCE: cfg_in.release_debounce = csr_pwdata[DEB_W-1:0];
            REG_SHORT_HOLD:       cfg_in.short_hold_ticks = csr_pwdata[TIME_W-1:0];
            REG_LONG_HOLD:        cfg_in.long_hold_ticks  = csr_pwdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_RELEASE_DEBOUNCE: csr_prdata = CSR_DW'(cfg_ff.release_debounce);
         REG_SHORT_HOLD:       csr_prdata = CSR_DW'(cfg_ff.short_hold_ticks);
         REG_LONG_HOLD:        csr_prdata = CSR_DW'(cfg_ff.long_hold_ticks);
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.release_debounce <= RELEASE_DEBOUNCE_RST;
         cfg_ff.short_hold_ticks <= SHORT_HOLD_RST;
         cfg_ff.long_hold_ticks  <= LONG_HOLD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: design/touch_long_press_classifier_top.sv
// Touch long-press classifier: an accepted input beat goes through the input register,
// then the classify step into the result register. Throughput is one beat per cycle
// while the result side keeps up; the only loop is the state update.
// Synchronous active-high reset clears the run, debounce and hold state and restores
// the threshold registers to their defaults. Depends on tlpc_pkg and tlpc_csr.
module touch_long_press_classifier_top
   import tlpc_pkg::*;
#(
   parameter int unsigned TIMER_BITS = 24
)(
   input  logic              clock,
   input  logic              reset,
   // Input channel.
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic              req_touch_level,
   input  logic [TIME_W-1:0] req_timer_now,
   input  logic              req_confirm_reset,
   input  logic              req_authorized,
   input  logic              req_locked,
   // Result channel.
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ACT_W-1:0]  rsp_action,
   output logic              rsp_running,
   output logic              rsp_touch_state,
   output logic [TIME_W-1:0] rsp_hold_time,
   // Configuration port.
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   // The timer wraps at TIMER_BITS bits. Values pass through a 32-bit
   // intermediate so that any width from 16 to 32 converts cleanly to and
   // from the 24-bit fields.
   localparam int unsigned WIDE_W = 32;

   cfg_type cfg;

   tlpc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // ------------------------------------------------------------------
   // Input register. A beat moves on into the classify step whenever the
   // result register is empty or is being drained in the same cycle, so
   // a new beat is taken every cycle while the consumer keeps up.
   // ------------------------------------------------------------------
   logic              item_valid_ff;
   logic [CMD_W-1:0]  item_cmd_ff;
   logic              item_touch_ff;
   logic [TIME_W-1:0] item_now_ff;
   logic              item_confirm_ff;
   logic              item_auth_ff;
   logic              item_locked_ff;

   logic rsp_valid_ff;
   logic advance;
   logic req_take;

   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_cmd_ff     <= req_cmd;
         item_touch_ff   <= req_touch_level;
         item_now_ff     <= req_timer_now;
         item_confirm_ff <= req_confirm_reset;
         item_auth_ff    <= req_authorized;
         item_locked_ff  <= req_locked;
      end
   end

   // ------------------------------------------------------------------
   // Detector state.
   // ------------------------------------------------------------------
   logic                  run_active_ff,   run_active_in;
   logic                  deb_touch_ff,    deb_touch_in;
   logic                  pend_touch_ff,   pend_touch_in;
   logic [DEB_W-1:0]      rel_count_ff,    rel_count_in;
   logic                  start_valid_ff,  start_valid_in;
   logic [TIMER_BITS-1:0] hold_start_ff,   hold_start_in;
   logic [TIME_W-1:0]     hold_ticks_ff,   hold_ticks_in;

   logic [ACT_W-1:0]      action;
   logic                  fired;
   logic [TIME_W-1:0]     ticks_now;
   logic [WIDE_W-1:0]     now_wide;
   logic [TIMER_BITS-1:0] now_t;
   logic [TIMER_BITS-1:0] elapsed;
   logic [WIDE_W-1:0]     elapsed_wide;

   // Wrapping hold time measured since the latched touch start.
   assign now_wide     = WIDE_W'(item_now_ff);
   assign now_t        = now_wide[TIMER_BITS-1:0];
   assign elapsed      = now_t - hold_start_ff;
   assign elapsed_wide = WIDE_W'(elapsed);

   // Classify step. A sample updates the release debounce, then the hold time;
   // a hold past the long threshold, or the short one without confirm or auth,
   // ends the run with one action; else a debounced level change starts or clears the hold.
   always_comb begin
      run_active_in  = run_active_ff;
      deb_touch_in   = deb_touch_ff;
      pend_touch_in  = pend_touch_ff;
      rel_count_in   = rel_count_ff;
      start_valid_in = start_valid_ff;
      hold_start_in  = hold_start_ff;
      hold_ticks_in  = hold_ticks_ff;
      action         = ACT_NONE;
      fired          = 1'b0;
      ticks_now      = hold_ticks_ff;

      unique case (item_cmd_ff)
         CMD_START: begin
            if (!run_active_ff) begin
               run_active_in = 1'b1;
               pend_touch_in = 1'b0;
               rel_count_in  = '0;
            end
         end
         CMD_STOP: begin
            if (run_active_ff) begin
               run_active_in  = 1'b0;
               deb_touch_in   = 1'b0;
               start_valid_in = 1'b0;
               hold_ticks_in  = '0;
            end
         end
         CMD_SAMPLE: begin
            if (run_active_ff) begin
               if (item_touch_ff) begin
                  pend_touch_in = 1'b1;
                  rel_count_in  = '0;
               end else if (deb_touch_ff) begin
                  if (rel_count_ff != RELEASE_COUNT_MAX) begin
                     rel_count_in = rel_count_ff + 1'b1;
                  end
                  if (rel_count_in > cfg.release_debounce) begin
                     pend_touch_in = 1'b0;
                     rel_count_in  = '0;
                  end
               end

               if (start_valid_ff) begin
                  ticks_now = elapsed_wide[TIME_W-1:0];
               end

               if (ticks_now > cfg.long_hold_ticks) begin
                  fired = 1'b1;
                  if (item_confirm_ff) begin
                     action = ACT_CONFIRM;
                  end else if (item_auth_ff) begin
                     action = ACT_UNLOCK;
                  end else begin
                     action = ACT_SHUTDOWN;
                  end
               end else if (ticks_now > cfg.short_hold_ticks &&
                            !item_confirm_ff && !item_auth_ff) begin
                  fired  = 1'b1;
                  action = item_locked_ff ? ACT_VALIDATE : ACT_LOCK;
               end

               if (fired) begin
                  run_active_in  = 1'b0;
                  deb_touch_in   = 1'b0;
                  start_valid_in = 1'b0;
                  hold_ticks_in  = '0;
               end else begin
                  hold_ticks_in = ticks_now;
                  if (pend_touch_in != deb_touch_ff) begin
                     deb_touch_in = pend_touch_in;
                     if (pend_touch_in) begin
                        hold_start_in  = now_t;
                        start_valid_in = 1'b1;
                     end else begin
                        start_valid_in = 1'b0;
                        hold_ticks_in  = '0;
                     end
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_active_ff  <= 1'b0;
         deb_touch_ff   <= 1'b0;
         pend_touch_ff  <= 1'b0;
         rel_count_ff   <= '0;
         start_valid_ff <= 1'b0;
         hold_start_ff  <= '0;
         hold_ticks_ff  <= '0;
      end else if (advance) begin
         run_active_ff  <= run_active_in;
         deb_touch_ff   <= deb_touch_in;
         pend_touch_ff  <= pend_touch_in;
         rel_count_ff   <= rel_count_in;
         start_valid_ff <= start_valid_in;
         hold_start_ff  <= hold_start_in;
         hold_ticks_ff  <= hold_ticks_in;
      end
   end

   // ------------------------------------------------------------------
   // Result register. It holds a finished beat until the consumer takes
   // it; meanwhile the input register can take one more beat, then stalls.
   // ------------------------------------------------------------------
   logic [ACT_W-1:0]  rsp_action_ff;
   logic              rsp_running_ff;
   logic              rsp_touch_ff;
   logic [TIME_W-1:0] rsp_hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // When an action fires, the reported hold is the one that caused it.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_action_ff  <= action;
         rsp_running_ff <= run_active_in;
         rsp_touch_ff   <= deb_touch_in;
         rsp_hold_ff    <= fired ? ticks_now : hold_ticks_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_action      = rsp_action_ff;
   assign rsp_running     = rsp_running_ff;
   assign rsp_touch_state = rsp_touch_ff;
   assign rsp_hold_time   = rsp_hold_ff;

endmodule

// File: design/tlpc_checker.sv
// Port-level checker for the touch long-press classifier, bound to the top level.
// Depends on tlpc_pkg for widths and action codes.
module tlpc_checker
   import tlpc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [ACT_W-1:0]  rsp_action,
   input logic              rsp_running,
   input logic              rsp_touch_state,
   input logic [TIME_W-1:0] rsp_hold_time,
   input logic              csr_pready
);

   // A stalled result beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action) &&
      $stable(rsp_hold_time) && $stable(rsp_running) && $stable(rsp_touch_state))
      else $error("result beat changed while stalled");

   // Any action ends the run and drops the debounced touch.
   a_action_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action != ACT_NONE |-> !rsp_running && !rsp_touch_state)
      else $error("action reported while run still active");

   // The debounced touch can only be set inside a run.
   a_touch_needs_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_running |-> !rsp_touch_state)
      else $error("touch state set outside a run");

   // Without a held touch and without an action, no hold time is reported.
   a_hold_needs_touch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_touch_state && rsp_action == ACT_NONE |-> rsp_hold_time == '0)
      else $error("hold time reported without a held touch");

   // The configuration port never inserts wait states.
   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("configuration port not ready");

endmodule

bind touch_long_press_classifier_top tlpc_checker u_tlpc_checker (.*);

// File: dv/touch_long_press_classifier_top_tb.sv
// Self-checking testbench for touch_long_press_classifier_top: drives press sessions,
// predicts every result beat and compares it field by field.
// Depends on tlpc_pkg and the touch_long_press_classifier_top design files.
`timescale 1ns / 1ps

module touch_long_press_classifier_top_tb
   import tlpc_pkg::*;
();

   // The package names no code for the fourth command value; the block ignores it.
   localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

   // Generous cycle budget. The slowest correct run is about 1100 beats, each paying at
   // most a sender gap, a receiver stall and the pipeline's delay.
   localparam int unsigned CYCLE_LIMIT = 600000;

   // These pauses give the pipeline ample room to settle.
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned TAIL_CYCLES   = 10;

   // A random phase stops after the session in which this many live beats are reached.
   localparam int unsigned PHASE_BEATS = 100;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic              touch;
      logic [TIME_W-1:0] now;
      logic              conf;
      logic              auth;
      logic              lock;
   } press_beat_type;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic              running;
      logic              touch_state;
      logic [TIME_W-1:0] hold_time;
   } press_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [CMD_W-1:0]  req_cmd = CMD_SAMPLE;
   logic              req_touch_level = 1'b0;
   logic [TIME_W-1:0] req_timer_now = '0;
   logic              req_confirm_reset = 1'b0;
   logic              req_authorized = 1'b0;
   logic              req_locked = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [ACT_W-1:0]  rsp_action;
   logic              rsp_running;
   logic              rsp_touch_state;
   logic [TIME_W-1:0] rsp_hold_time;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   touch_long_press_classifier_top u_top (.*);

   // Shadow copy of the threshold registers and of the detector state. It is advanced
   // once per accepted input beat, in acceptance order.
   cfg_type           cfg_shadow;
   logic              run_on;
   logic              deb_touch;
   logic              pend_touch;
   logic [DEB_W-1:0]  rel_cnt;
   logic              hold_armed;
   logic [TIME_W-1:0] hold_origin;
   logic [TIME_W-1:0] held;

   // Set by the classifier when a beat actually touched the detector state, so that
   // ignored beats do not count toward a phase.
   logic              beat_counted;
   int unsigned       live_beats = 0;

   press_result_type  expected_results[$];
   int unsigned       mismatches = 0;
   int unsigned       cycle_count = 0;

   // When set, neither side inserts gaps; this gives stretches at full rate.
   logic              steady = 1'b0;
   int                stall_left = 0;
   int unsigned       tick_max = 16;

   initial begin
      forever #5 clock = ~clock;
   end

   // The run is cut off here if the block stops answering.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("touch_long_press_classifier_top test failed");
         $finish;
      end
   end

   // Mostly short gaps with the occasional long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 2);
      else if (r < 92)
         return $urandom_range(3, 6);
      else
         return $urandom_range(10, 40);
   endfunction

   // Result-side back-pressure: a stall starts on about one edge in five and lasts a
   // random gap, unless a steady stretch is in progress.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 4) == 0) begin
         stall_left <= pick_gap() - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic report_mismatch(input string what);
      $display("%0t ns: MISMATCH %s", $time, what);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
   endtask

   // Every accepted result beat is matched against the oldest pending prediction.
   always @(posedge clock) begin : result_checker
      press_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result beat arrived with no prediction pending");
         end else begin
            want = expected_results.pop_front();
            check_field("action", 32'(rsp_action), 32'(want.action));
            check_field("running", 32'(rsp_running), 32'(want.running));
            check_field("touch_state", 32'(rsp_touch_state), 32'(want.touch_state));
            check_field("hold_time", 32'(rsp_hold_time), 32'(want.hold_time));
         end
      end
   end

   // Closing a run, whether by an action or by a stop command.
   function automatic void end_hold_run();
      run_on = 1'b0;
      deb_touch = 1'b0;
      hold_armed = 1'b0;
      held = '0;
   endfunction

   function automatic void reset_detector();
      cfg_shadow.release_debounce = RELEASE_DEBOUNCE_RST;
      cfg_shadow.short_hold_ticks = SHORT_HOLD_RST;
      cfg_shadow.long_hold_ticks = LONG_HOLD_RST;
      run_on = 1'b0;
      deb_touch = 1'b0;
      pend_touch = 1'b0;
      rel_cnt = '0;
      hold_armed = 1'b0;
      hold_origin = '0;
      held = '0;
   endfunction

   // Advances the detector by one input beat and returns the result it must produce.
   function automatic press_result_type classify_beat(input press_beat_type b);
      press_result_type res;
      logic             fired;
      res.action = ACT_NONE;
      fired = 1'b0;
      beat_counted = 1'b0;
      if (b.cmd == CMD_START) begin
         if (!run_on) begin
            run_on = 1'b1;
            pend_touch = 1'b0;
            rel_cnt = '0;
            beat_counted = 1'b1;
         end
      end else if (b.cmd == CMD_STOP) begin
         if (run_on) begin
            end_hold_run();
            beat_counted = 1'b1;
         end
      end else if (b.cmd == CMD_SAMPLE && run_on) begin
         beat_counted = 1'b1;
         // A touch registers at once; a release only after the untouched count
         // passes the debounce setting. The count sticks at its top value.
         if (b.touch) begin
            pend_touch = 1'b1;
            rel_cnt = '0;
         end else if (deb_touch) begin
            if (rel_cnt != RELEASE_COUNT_MAX)
               rel_cnt = rel_cnt + 1'b1;
            if (rel_cnt > cfg_shadow.release_debounce) begin
               pend_touch = 1'b0;
               rel_cnt = '0;
            end
         end
         // Hold time wraps with the timer.
         if (hold_armed)
            held = b.now - hold_origin;
         if (held > cfg_shadow.long_hold_ticks) begin
            res.action = b.conf ? ACT_CONFIRM : (b.auth ? ACT_UNLOCK : ACT_SHUTDOWN);
            fired = 1'b1;
         end else if (held > cfg_shadow.short_hold_ticks && !b.conf && !b.auth) begin
            res.action = b.lock ? ACT_VALIDATE : ACT_LOCK;
            fired = 1'b1;
         end
         // An action reports the hold that caused it and closes the run.
         if (fired) begin
            res.running = 1'b0;
            res.touch_state = 1'b0;
            res.hold_time = held;
            end_hold_run();
            return res;
         end
         if (pend_touch != deb_touch) begin
            deb_touch = pend_touch;
            if (pend_touch) begin
               hold_origin = b.now;
               hold_armed = 1'b1;
            end else begin
               hold_armed = 1'b0;
               held = '0;
            end
         end
      end
      res.running = run_on;
      res.touch_state = deb_touch;
      res.hold_time = held;
      return res;
   endfunction

   // Sends one input beat. Called at a rising edge; returns at the edge that accepted
   // the beat, with valid still high so that a following beat can go out back to back.
   task automatic send_beat(input press_beat_type b);
      int gap;
      gap = steady ? 0 : (($urandom_range(0, 2) == 0) ? pick_gap() : 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= b.cmd;
      req_touch_level <= b.touch;
      req_timer_now <= b.now;
      req_confirm_reset <= b.conf;
      req_authorized <= b.auth;
      req_locked <= b.lock;
      do @(posedge clock); while (!req_ready);
      expected_results.push_back(classify_beat(b));
      if (beat_counted)
         live_beats++;
   endtask

   task automatic send_sample(input logic touch, input logic [TIME_W-1:0] now,
                              input logic conf, input logic auth, input logic lock);
      press_beat_type b;
      b.cmd = CMD_SAMPLE;
      b.touch = touch;
      b.now = now;
      b.conf = conf;
      b.auth = auth;
      b.lock = lock;
      send_beat(b);
   endtask

   // Commands other than a sample carry random payload, which the block must ignore.
   task automatic send_cmd(input logic [CMD_W-1:0] cmd);
      press_beat_type b;
      b.cmd = cmd;
      b.touch = 1'($urandom_range(0, 1));
      b.now = TIME_W'($urandom_range(0, 24'hFFFFFF));
      b.conf = 1'($urandom_range(0, 1));
      b.auth = 1'($urandom_range(0, 1));
      b.lock = 1'($urandom_range(0, 1));
      send_beat(b);
   endtask

   // Waits until every prediction has been matched, then lets the pipeline settle.
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The bus goes idle after each transfer.
   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_RELEASE_DEBOUNCE: cfg_shadow.release_debounce = data[DEB_W-1:0];
         REG_SHORT_HOLD:       cfg_shadow.short_hold_ticks = data[TIME_W-1:0];
         REG_LONG_HOLD:        cfg_shadow.long_hold_ticks = data[TIME_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Reads a register back and compares it with the shadow copy.
   task automatic csr_expect(input logic [REG_IDX_W-1:0] idx);
      logic [31:0] want;
      case (idx)
         REG_RELEASE_DEBOUNCE: want = 32'(cfg_shadow.release_debounce);
         REG_SHORT_HOLD:       want = 32'(cfg_shadow.short_hold_ticks);
         default:              want = 32'(cfg_shadow.long_hold_ticks);
      endcase
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      check_field($sformatf("register %0d readback", idx), csr_prdata, want);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_thresholds(input logic [DEB_W-1:0] deb,
                                 input logic [TIME_W-1:0] short_ticks,
                                 input logic [TIME_W-1:0] long_ticks);
      csr_write(REG_RELEASE_DEBOUNCE, 32'(deb));
      csr_write(REG_SHORT_HOLD, 32'(short_ticks));
      csr_write(REG_LONG_HOLD, 32'(long_ticks));
   endtask

   // Reset values first, then every register at both ends of its range. Junk in the
   // unused upper data bits must not land in the register.
   task automatic test_register_access();
      csr_expect(REG_RELEASE_DEBOUNCE);
      csr_expect(REG_SHORT_HOLD);
      csr_expect(REG_LONG_HOLD);
      csr_write(REG_RELEASE_DEBOUNCE, 32'hFFFF_FF00);
      csr_expect(REG_RELEASE_DEBOUNCE);
      csr_write(REG_RELEASE_DEBOUNCE, 32'h0000_00FF);
      csr_expect(REG_RELEASE_DEBOUNCE);
      csr_write(REG_SHORT_HOLD, 32'hFF00_0000);
      csr_expect(REG_SHORT_HOLD);
      csr_write(REG_SHORT_HOLD, 32'h00FF_FFFF);
      csr_expect(REG_SHORT_HOLD);
      csr_write(REG_LONG_HOLD, 32'hFF00_0000);
      csr_expect(REG_LONG_HOLD);
      csr_write(REG_LONG_HOLD, 32'h00FF_FFFF);
      csr_expect(REG_LONG_HOLD);
      set_thresholds(RELEASE_DEBOUNCE_RST, SHORT_HOLD_RST, LONG_HOLD_RST);
   endtask

   // Hand-picked beats at the default thresholds: ignored commands, every action,
   // a hold measured across the timer wrap, and a debounced release.
   task automatic test_directed_presses();
      // Idle: a sample, the unused command and a stop all leave the state alone.
      send_sample(1'b1, 24'hFFFFFF, 1'b1, 1'b1, 1'b1);
      send_cmd(CMD_RESERVED);
      send_cmd(CMD_STOP);
      // A second start while running is ignored.
      send_cmd(CMD_START);
      send_cmd(CMD_START);
      // Touch just below the timer top; the hold keeps counting across the wrap and
      // a bouncing untouched sample does not release.
      send_sample(1'b1, 24'hFFFFF0, 1'b0, 1'b0, 1'b0);
      send_sample(1'b0, 24'h000010, 1'b1, 1'b0, 1'b0);
      send_sample(1'b1, 24'hFFFFF0 + 24'd327681, 1'b1, 1'b0, 1'b0);
      // The long hold with confirmation pending gave confirm reset; run is over now.
      send_sample(1'b1, 24'h000000, 1'b0, 1'b0, 1'b0);
      // Long hold while authorized: unlock.
      send_cmd(CMD_START);
      send_sample(1'b1, 24'h000000, 1'b0, 1'b1, 1'b0);
      send_sample(1'b1, 24'd327681, 1'b0, 1'b1, 1'b1);
      // Long hold with no flags: shutdown, at the largest hold the timer allows.
      send_cmd(CMD_START);
      send_sample(1'b1, 24'h000001, 1'b0, 1'b0, 1'b0);
      send_sample(1'b1, 24'h000000, 1'b0, 1'b0, 1'b0);
      // Short hold while locked: validate fingerprint.
      send_cmd(CMD_START);
      send_sample(1'b1, 24'h000000, 1'b0, 1'b0, 1'b1);
      send_sample(1'b1, 24'd78644, 1'b0, 1'b0, 1'b1);
      // Short hold is held back while authorized, then fires as lock.
      send_cmd(CMD_START);
      send_sample(1'b1, 24'h000000, 1'b0, 1'b0, 1'b0);
      send_sample(1'b1, 24'd78644, 1'b0, 1'b1, 1'b0);
      send_sample(1'b1, 24'd100000, 1'b0, 1'b0, 1'b0);
      // Release after more than three untouched samples, then stop the run.
      send_cmd(CMD_START);
      send_sample(1'b1, 24'h000100, 1'b0, 1'b0, 1'b0);
      repeat (4) send_sample(1'b0, 24'h000110, 1'b0, 1'b0, 1'b0);
      send_cmd(CMD_STOP);
      wait_results_drained();
   endtask

   // With the debounce at its top the release counter saturates and the pad never
   // reads as released. Thresholds at their top keep any action from firing.
   task automatic test_release_saturation();
      set_thresholds(8'hFF, 24'hFFFFFF, 24'hFFFFFF);
      send_cmd(CMD_START);
      send_sample(1'b1, TIME_W'($urandom_range(0, 24'hFFFFFF)), 1'b0, 1'b0, 1'b0);
      repeat (262)
         send_sample(1'b0, TIME_W'($urandom_range(0, 24'hFFFFFF)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
      send_cmd(CMD_STOP);
      wait_results_drained();
   endtask

   function automatic logic [TIME_W-1:0] next_step();
      if ($urandom_range(0, 15) == 0)
         return TIME_W'($urandom_range(0, 24'hFFFFFF));
      return TIME_W'($urandom_range(0, tick_max));
   endfunction

   // One detector run: a start, then touch and release bursts with the timer moving
   // forward, with the odd stray command mixed in. Release bursts are sized around
   // the debounce setting so that some release and some only bounce.
   task automatic press_session();
      logic [TIME_W-1:0] now;
      logic              touching;
      int                burst;
      int                n;
      int                rel_cap;
      if ($urandom_range(0, 7) == 0)
         send_cmd(CMD_W'($urandom_range(0, 3)));
      send_cmd(CMD_START);
      now = TIME_W'($urandom_range(0, 24'hFFFFFF));
      touching = 1'b0;
      burst = $urandom_range(0, 2);
      n = $urandom_range(3, 60);
      for (int i = 0; i < n && run_on; i++) begin
         if ($urandom_range(0, 39) == 0) begin
            send_cmd(CMD_START);
         end else if ($urandom_range(0, 59) == 0) begin
            send_cmd(CMD_STOP);
         end else begin
            if (burst == 0) begin
               touching = !touching;
               rel_cap = (cfg_shadow.release_debounce > 38) ? 40
                                                            : cfg_shadow.release_debounce + 2;
               burst = touching ? $urandom_range(1, 30) : $urandom_range(1, rel_cap);
            end
            burst--;
            now = now + next_step();
            send_sample(touching, now, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                        1'($urandom_range(0, 1)));
         end
      end
      if (run_on && $urandom_range(0, 1) == 1)
         send_cmd(CMD_STOP);
   endtask

   task automatic random_phase(input logic [DEB_W-1:0] deb, input logic [TIME_W-1:0] short_ticks,
                               input logic [TIME_W-1:0] long_ticks, input int unsigned step_max,
                               input logic no_gaps);
      int unsigned first;
      wait_results_drained();
      set_thresholds(deb, short_ticks, long_ticks);
      tick_max = step_max;
      steady <= no_gaps;
      first = live_beats;
      while (live_beats - first < PHASE_BEATS)
         press_session();
      steady <= 1'b0;
   endtask

   // Several threshold settings, the extremes among them. Two phases run with no
   // gaps on either side.
   task automatic test_random_sessions();
      random_phase(8'd3, 24'd60, 24'd150, 12, 1'b0);
      random_phase(8'd0, 24'd0, 24'd0, 4, 1'b1);
      random_phase(8'd254, 24'hFFFFFF, 24'hFFFFFF, 2000, 1'b0);
      random_phase(DEB_W'($urandom_range(0, 8)), TIME_W'($urandom_range(0, 300)),
                   TIME_W'($urandom_range(0, 600)), 30, 1'b0);
      random_phase(8'd1, 24'hFFFFFF, 24'd100, 10, 1'b1);
      random_phase(DEB_W'($urandom_range(0, 254)), TIME_W'($urandom_range(0, 24'hFFFFFF)),
                   TIME_W'($urandom_range(0, 24'hFFFFFF)), 24'hFFFFFF, 1'b0);
   endtask

   initial begin
      reset_detector();
      reset <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_register_access();
      test_directed_presses();
      test_release_saturation();
      test_random_sessions();
      wait_results_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("touch_long_press_classifier_top test passed");
      else
         $display("touch_long_press_classifier_top test failed");
      $finish;
   end

endmodule

// File: sim.f
design/tlpc_pkg.sv
design/tlpc_csr.sv
design/touch_long_press_classifier_top.sv
design/tlpc_checker.sv
dv/touch_long_press_classifier_top_tb.sv
